@@ hw/rtl/dkrs_pkg.sv @@
//------------------------------------------------------------------------------
// dkrs_pkg
// Shared types and constants for the date keyed record sorter.
//------------------------------------------------------------------------------
`default_nettype none

package dkrs_pkg;

	// Default store depth
	localparam int CAPACITY_DEF = 64;

	// Field widths
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int SEQ_W   = 7;
	localparam int REC_W   = YEAR_W + MONTH_W + DAY_W + SEQ_W;

	// Stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	// Stored record: year in the top bits, so a plain unsigned compare orders
	// by date and then by arrival
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [SEQ_W-1:0]   seq;
	} record_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMIT_OUT
	} seq_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/dkrs_store.sv @@
//------------------------------------------------------------------------------
// dkrs_store
// Record memory: one write port, one read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module dkrs_store
	import dkrs_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire record_t       wdata,
	input  wire logic [AW-1:0] raddr,
	output record_t            rdata
);

	record_t mem [DEPTH];
	record_t rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/dkrs_seq.sv @@
//------------------------------------------------------------------------------
// dkrs_seq
// Sequencer: insertion sort into the record memory with one shared comparator,
// then read-out of the sorted batch through an output register.
//------------------------------------------------------------------------------
`default_nettype none

module dkrs_seq
	import dkrs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input beats
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [YEAR_W-1:0]  in_year,
	input  wire logic [MONTH_W-1:0] in_month,
	input  wire logic [DAY_W-1:0]   in_day,
	input  wire logic               in_last,
	// result beats
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output record_t                 out_rec,
	output logic                    out_last,
	output logic                    out_overflow,
	// memory port
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output record_t                 mem_wdata,
	output logic [AW-1:0]           mem_raddr,
	input  wire record_t            mem_rdata
);

	seq_state_t      state_q, state_d;
	record_t         rec_q;
	record_t         out_q;
	logic            last_q;
	logic            ovf_q;
	logic [AW-1:0]   idx_q;
	logic [CW-1:0]   count_q;

	logic            in_acc;
	logic            full;
	logic            shift_c;
	logic            emit_end;
	logic            out_acc;
	logic [AW-1:0]   idx_m1;
	logic [AW-1:0]   idx_m2;

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign emit_end = ((CW'(idx_q) + CW'(1)) == count_q);

	// Guarded neighbour addresses, never outside the store
	assign idx_m1 = (idx_q == '0) ? '0 : idx_q - AW'(1);
	assign idx_m2 = (CW'(idx_q) < CW'(2)) ? '0 : idx_q - AW'(2);

	// Shared comparator: stored neighbour above the new record moves up
	assign shift_c = (idx_q != '0) && (mem_rdata > rec_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!full) begin
						state_d = ST_INS_RD;
					end else if (in_last) begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_INS_RD: begin
				state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				if (!shift_c) begin
					state_d = last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (out_acc) begin
					state_d = emit_end ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs and memory control
	always_comb begin
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rec_q;
		mem_raddr = idx_m1;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_INS_RD: begin
				mem_raddr = idx_m1;
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				if (shift_c) begin
					mem_wdata = mem_rdata;
					mem_raddr = idx_m2;
				end
			end
			ST_EMIT_RD: begin
				mem_raddr = idx_q;
			end
			ST_EMIT_LD: begin
				mem_raddr = idx_q;
			end
			ST_EMIT_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Batch bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
							idx_q <= '0;
						end else begin
							idx_q <= count_q[AW-1:0];
						end
					end
				end
				ST_INS_CMP: begin
					if (shift_c) begin
						idx_q <= idx_m1;
					end else begin
						count_q <= count_q + CW'(1);
						idx_q   <= '0;
					end
				end
				ST_EMIT_OUT: begin
					if (out_acc) begin
						if (emit_end) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + AW'(1);
						end
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// Record being inserted and end-of-batch mark
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rec_q.year  <= in_year;
			rec_q.month <= in_month;
			rec_q.day   <= in_day;
			rec_q.seq   <= SEQ_W'(count_q) + SEQ_W'(1);
			last_q      <= in_last;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_q <= mem_rdata;
		end
	end

	assign out_rec      = out_q;
	assign out_last     = emit_end;
	assign out_overflow = ovf_q;

endmodule

`default_nettype wire

@@ hw/rtl/date_keyed_record_sorter.sv @@
//------------------------------------------------------------------------------
// date_keyed_record_sorter
// Collects a batch of dated records and returns them sorted by date.
//------------------------------------------------------------------------------
// Usage
//   s_* : one record per beat, tdata = year, month, day from bit 0 up,
//         tlast closes the batch. Records beyond CAPACITY are dropped.
//   m_* : sorted records, one per beat, emitted only after a closing beat.
//         tdata holds sequence number, year, month, day from bit 0 up;
//         tuser is the overflow flag of the batch; tlast marks the last one.
// Insertion and read-out
//   A record is inserted by walking the sorted store downwards with one
//   comparator and one read and one write port, one entry per cycle, through
//   the states ST_INS_RD and ST_INS_CMP. A dropped record only sets the
//   overflow flag. Each result passes ST_EMIT_RD, ST_EMIT_LD and ST_EMIT_OUT.
//   s_tready is low while a record is inserted or the batch is read out.
// Reset and stall
//   Reset empties the batch. A stalled result holds on m_* until taken; the
//   block waits meanwhile. After the last result the batch starts empty.
//------------------------------------------------------------------------------
`default_nettype none

module date_keyed_record_sorter
	import dkrs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // birth_year, birth_month, birth_day
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // sequence_number, out_year, out_month, out_day
	output logic                        m_tuser,  // overflow
	output logic                        m_tlast
);

	localparam int AW = $clog2(CAPACITY);

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	record_t         mem_wdata;
	logic [AW-1:0]   mem_raddr;
	record_t         mem_rdata;
	record_t         out_rec;

	dkrs_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.in_year      (s_tdata[YEAR_W-1:0]),
		.in_month     (s_tdata[YEAR_W+MONTH_W-1:YEAR_W]),
		.in_day       (s_tdata[YEAR_W+MONTH_W+DAY_W-1:YEAR_W+MONTH_W]),
		.in_last      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.out_rec      (out_rec),
		.out_last     (m_tlast),
		.out_overflow (m_tuser),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	dkrs_store #(
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result beat packing, sequence number lowest
	assign m_tdata = {2'b00, out_rec.day, out_rec.month, out_rec.year, out_rec.seq};

endmodule

`default_nettype wire

@@ hw/rtl/dkrs_checker.sv @@
//------------------------------------------------------------------------------
// dkrs_props
// Port-level checks for the date keyed record sorter, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module dkrs_props
	import dkrs_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   s_tlast,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tuser,
	input wire logic                   m_tlast
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed under stall");

	// No record taken while results are offered
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during read-out");

	// A closing beat stops further input next cycle
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input ready right after closing beat");

	// After the final result of a batch nothing more is offered at once
	a_batch_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("result offered right after the final one");

endmodule

bind date_keyed_record_sorter dkrs_props u_dkrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

@@ sim/dkrs_checker.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// dkrs_checker
// Watches both stream channels of the date keyed record sorter, keeps its own
// sorted copy of the current batch and compares every output beat against it.
//------------------------------------------------------------------------------
module dkrs_checker
	import dkrs_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // birth_year, birth_month, birth_day
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,  // sequence_number, out_year, out_month, out_day
	input  logic                   m_tuser,  // overflow
	input  logic                   m_tlast,
	output int                     fail_count,
	output int                     results_pending
);

	localparam int MAX_REPORTS = 40;

	// One sorted record as it should leave the block
	typedef struct {
		logic [SEQ_W-1:0]   seq;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               overflow;
		logic               fin;
	} sorted_beat_t;

	record_t      batch_store[$];   // current batch, kept in date order
	logic         dropped_seen;
	sorted_beat_t sorted_due[$];    // beats still owed by the block

	// Note a mismatch, printing only the first few
	task automatic flag_mismatch(input string what, input int want, input int got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Insert one record in date order; a closing beat releases the whole batch
	task automatic file_record(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
			input logic [DAY_W-1:0] dy, input logic fin);
		record_t      rec;
		sorted_beat_t beat;
		int           pos;
		if (batch_store.size() >= CAPACITY) begin
			dropped_seen = 1'b1;
		end else begin
			rec.year  = yr;
			rec.month = mo;
			rec.day   = dy;
			rec.seq   = SEQ_W'(batch_store.size() + 1);
			// seq in the low bits keeps equal dates in arrival order
			pos = batch_store.size();
			while (pos > 0 && batch_store[pos-1] > rec)
				pos--;
			batch_store.insert(pos, rec);
		end
		if (fin) begin
			foreach (batch_store[k]) begin
				beat.seq      = batch_store[k].seq;
				beat.year     = batch_store[k].year;
				beat.month    = batch_store[k].month;
				beat.day      = batch_store[k].day;
				beat.overflow = dropped_seen;
				beat.fin      = (k == batch_store.size() - 1);
				sorted_due.push_back(beat);
			end
			batch_store.delete();
			dropped_seen = 1'b0;
		end
	endtask

	// Compare one output beat with the oldest owed beat
	task automatic check_beat();
		sorted_beat_t want;
		if (sorted_due.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: unexpected output beat, expected none, actual tdata %h",
					$time, m_tdata);
		end else begin
			want = sorted_due.pop_front();
			if (m_tdata[SEQ_W-1:0] !== want.seq)
				flag_mismatch("sequence_number", want.seq, m_tdata[SEQ_W-1:0]);
			if (m_tdata[SEQ_W +: YEAR_W] !== want.year)
				flag_mismatch("out_year", want.year, m_tdata[SEQ_W +: YEAR_W]);
			if (m_tdata[SEQ_W+YEAR_W +: MONTH_W] !== want.month)
				flag_mismatch("out_month", want.month, m_tdata[SEQ_W+YEAR_W +: MONTH_W]);
			if (m_tdata[SEQ_W+YEAR_W+MONTH_W +: DAY_W] !== want.day)
				flag_mismatch("out_day", want.day, m_tdata[SEQ_W+YEAR_W+MONTH_W +: DAY_W]);
			if (m_tuser !== want.overflow)
				flag_mismatch("overflow", want.overflow, m_tuser);
			if (m_tlast !== want.fin)
				flag_mismatch("last_result", want.fin, m_tlast);
		end
	endtask

	// Sample both channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_store.delete();
			sorted_due.delete();
			dropped_seen    = 1'b0;
			fail_count      = 0;
			results_pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				file_record(s_tdata[YEAR_W-1:0], s_tdata[YEAR_W +: MONTH_W],
					s_tdata[YEAR_W+MONTH_W +: DAY_W], s_tlast);
			if (m_tvalid && m_tready)
				check_beat();
			results_pending = sorted_due.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the date keyed record sorter: directed batches
// covering field extremes and ties, then random batches including full and
// overflowing ones, with random idling on both channels and one long stall.
//------------------------------------------------------------------------------
module tb_top
	import dkrs_pkg::*;
();

	localparam int CAPACITY       = CAPACITY_DEF;
	localparam int TOTAL_ITEMS    = 430;
	localparam int QUIET_FROM     = 370;   // no idling beyond this many beats
	localparam int DIRECTED_ITEMS = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 200;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // birth_year, birth_month, birth_day
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // sequence_number, out_year, out_month, out_day
	logic                   m_tuser;   // overflow
	logic                   m_tlast;
	int                     fail_count;
	int                     results_pending;

	int unsigned sent_items  = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic        quiet       = 1'b0;
	logic        hold_done   = 1'b0;

	date_keyed_record_sorter #(
		.CAPACITY (CAPACITY)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	dkrs_checker #(
		.CAPACITY (CAPACITY)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one record, with an optional idle burst first; returns at a falling edge
	task automatic send_record(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
			input logic [DAY_W-1:0] dy, input logic fin);
		logic [IN_TDATA_W-1:0] word;
		int unsigned           gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < tx_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		word = '0;
		word[YEAR_W-1:0]              = yr;
		word[YEAR_W +: MONTH_W]       = mo;
		word[YEAR_W+MONTH_W +: DAY_W] = dy;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		sent_items++;
		if (sent_items >= QUIET_FROM)
			quiet = 1'b1;
		@(negedge clk);
	endtask

	// Receiver: random stall bursts, plus one long hold-off once results flow
	initial begin
		int unsigned stall_left;
		int unsigned phase_cycles;
		stall_left   = 0;
		phase_cycles = 0;
		m_tready     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			phase_cycles++;
			if (phase_cycles % 200 == 0)
				case ($urandom_range(0, 2))
					0:       rx_idle_pct = 0;
					1:       rx_idle_pct = 10;
					default: rx_idle_pct = 30;
				endcase
			if (stall_left == 0) begin
				if (!hold_done && m_tvalid && sent_items > DIRECTED_ITEMS) begin
					hold_done  = 1'b1;
					stall_left = HOLD_CYCLES;
				end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
					stall_left = $urandom_range(1, 6);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles in a row with no beat on either channel
	initial begin
		int unsigned dead_cycles;
		dead_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				dead_cycles = 0;
			else
				dead_cycles++;
			if (dead_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int unsigned batch_no;
		int unsigned batch_len;
		logic [YEAR_W-1:0]  yr;
		logic [MONTH_W-1:0] mo;
		logic [DAY_W-1:0]   dy;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Extremes, out-of-range values, and a three-way tie released last
		tx_idle_pct = 20;
		send_record(14'd0,     4'd0,  5'd0,  1'b0);
		send_record(14'd9999,  4'd12, 5'd31, 1'b0);
		send_record(14'd16383, 4'd15, 5'd31, 1'b0);
		send_record(14'd2000,  4'd6,  5'd15, 1'b0);
		send_record(14'd2000,  4'd6,  5'd15, 1'b0);
		send_record(14'd2000,  4'd6,  5'd14, 1'b0);
		send_record(14'd2000,  4'd5,  5'd31, 1'b0);
		send_record(14'd1999,  4'd12, 5'd31, 1'b0);
		send_record(14'd0,     4'd0,  5'd1,  1'b0);
		send_record(14'd2000,  4'd6,  5'd15, 1'b1);
		// Single-record batch
		send_record(14'd5000,  4'd7,  5'd7,  1'b1);
		// Alternating bit patterns, arriving in descending order
		send_record(14'h2AAA,  4'hA,  5'h15, 1'b0);
		send_record(14'h1555,  4'h5,  5'h0A, 1'b1);
		// Identical dates throughout
		send_record(14'd1,     4'd1,  5'd1,  1'b0);
		send_record(14'd1,     4'd1,  5'd1,  1'b0);
		send_record(14'd1,     4'd1,  5'd1,  1'b1);

		// Random batches: mostly short, with a full one and an overflowing one
		batch_no = 0;
		while (sent_items < TOTAL_ITEMS) begin
			if (batch_no == 1)
				batch_len = CAPACITY;
			else if (batch_no == 4)
				batch_len = CAPACITY + 2;       // closing beat itself is dropped
			else if ($urandom_range(0, 11) == 0)
				batch_len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
			else
				batch_len = $urandom_range(1, 9);
			case ($urandom_range(0, 3))
				0, 1:    tx_idle_pct = 0;
				2:       tx_idle_pct = 15;
				default: tx_idle_pct = 40;
			endcase
			for (int unsigned i = 0; i < batch_len; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						yr = YEAR_W'($urandom_range(0, 16383));
						mo = MONTH_W'($urandom_range(0, 15));
						dy = DAY_W'($urandom_range(0, 31));
					end
					4, 5, 6: begin
						yr = YEAR_W'($urandom_range(1900, 2100));
						mo = MONTH_W'($urandom_range(1, 12));
						dy = DAY_W'($urandom_range(1, 28));
					end
					default: begin
						// small pool so that equal dates are common
						yr = YEAR_W'($urandom_range(1990, 1991));
						mo = MONTH_W'($urandom_range(1, 2));
						dy = DAY_W'($urandom_range(1, 2));
					end
				endcase
				send_record(yr, mo, dy, i == batch_len - 1);
			end
			batch_no++;
		end
		s_tvalid <= 1'b0;
		s_tlast  <= 1'b0;

		// Drain, then a quiet tail to catch stray beats
		while (results_pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0 && results_pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
